// ----- sv/ttlb_pkg.sv -----
// shared types and constants for the text terminal line buffer
package ttlb_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 64;

  // output queue
  localparam int OQ_AW    = 2;
  localparam int OQ_DEPTH = 1 << OQ_AW;

  // register reset values
  localparam logic [6:0]  RST_COLUMNS = 7'd64;
  localparam logic [5:0]  RST_ROWS    = 6'd32;
  localparam logic [15:0] RST_COLOR   = 16'hFFFF;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_DEL = 8'd127;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    EV_DRAW   = 3'd0,
    EV_ERASE  = 3'd1,
    EV_REDRAW = 3'd2,
    EV_CURSOR = 3'd3,
    EV_READ   = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS   = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_CURSOR_EN = 2'd2,
    CFG_COLOR     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    event_kind_t kind;
    logic [4:0]  row;
    logic [5:0]  col;
    logic [7:0]  ch;
    logic [15:0] color;
    logic        shown;
    logic        last;
  } result_t;

  // up to two results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    ev;
  } push_t;

endpackage

// ----- sv/ttlb_in_if.sv -----
// input item channel of the text terminal line buffer
interface ttlb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [15:0] text_color;
  logic [4:0]  read_row;
  logic [5:0]  read_col;

  modport source (
    output valid, opcode, char_code, text_color, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, opcode, char_code, text_color, read_row, read_col,
    output ready
  );
endinterface

// ----- sv/ttlb_out_if.sv -----
// result item channel of the text terminal line buffer
interface ttlb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [4:0]  cell_row;
  logic [5:0]  cell_col;
  logic [7:0]  cell_char;
  logic [15:0] cell_color;
  logic        cursor_shown;
  logic        last_of_run;

  modport source (
    output valid, event_kind, cell_row, cell_col, cell_char, cell_color,
           cursor_shown, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, cell_row, cell_col, cell_char, cell_color,
           cursor_shown, last_of_run,
    output ready
  );
endinterface

// ----- sv/ttlb_out_fifo.sv -----
// result queue taking up to two items per cycle and driving the result channel
module ttlb_out_fifo
  import ttlb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  push_t             push,
  output logic [OQ_AW:0]    free,
  ttlb_out_if.source        out_item
);

  result_t            q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]   wp_r, wp_nxt;
  logic [OQ_AW-1:0]   rp_r, rp_nxt;
  logic [OQ_AW:0]     cnt_r, cnt_nxt;
  logic               pop;
  result_t            head;

  assign pop  = out_item.valid && out_item.ready;
  assign free = (OQ_AW + 1)'(OQ_DEPTH) - cnt_r;

  always_comb begin
    wp_nxt  = wp_r + OQ_AW'(push.count);
    rp_nxt  = pop ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (OQ_AW + 1)'(push.count) - (OQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_mem[wp_r] <= push.ev[0];
    end
    if (push.count == 2'd2) begin
      q_mem[wp_r + OQ_AW'(1)] <= push.ev[1];
    end
  end

  assign head                  = q_mem[rp_r];
  assign out_item.valid        = (cnt_r != '0);
  assign out_item.event_kind   = head.kind;
  assign out_item.cell_row     = head.row;
  assign out_item.cell_col     = head.col;
  assign out_item.cell_char    = head.ch;
  assign out_item.cell_color   = head.color;
  assign out_item.cursor_shown = head.shown;
  assign out_item.last_of_run  = head.last;

endmodule

// ----- sv/text_terminal_line_buffer.sv -----
// top level of the text terminal line buffer: row store, cursor state, command execution
//
// Usage: commands arrive on in_item (put character, clear, cursor tick, read
// cell); drawing events leave on out_item as cell coordinates, up to two per
// command, the final one flagged by last_of_run. Registers are written on the
// cfg_ port (cfg_we, cfg_index, cfg_wdata), only while no command is in
// flight: the user must keep to this, the block does not enforce it.
// Timing: a command is taken in the cycle its character and row memories
// are read, and executed in the next, where the read-modify-write lands and
// its events enter a four-entry result queue. A new command is taken only
// once the previous one has executed, as a memory read lies in front of each
// update. The first event is valid on out_item once it is in the queue.
// Reset: rows empty with color 0xFFFF, one row in use, cursor at column 0 and
// hidden; per-row valid bits clear at reset, so there is no clearing pass and
// in_item.ready rises right after reset. The character memory is never
// cleared; cells past a row's length read as 0.
// Stall: when out_item.ready stays low the queue fills and in_item.ready drops
// while fewer than two entries are free; nothing is lost or repeated.
module text_terminal_line_buffer
  import ttlb_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic         clk,
  input  logic         rst_n,
  ttlb_in_if.sink      in_item,
  ttlb_out_if.source   out_item,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int PW       = $clog2(MAX_ROWS);
  localparam int RW       = $clog2(MAX_ROWS + 1);
  localparam int CW       = $clog2(MAX_COLS);
  localparam int CLW      = $clog2(MAX_COLS + 1);
  localparam int AW       = PW + CW;
  localparam int CS_DEPTH = MAX_ROWS * (2 ** CW);
  localparam int MW       = CLW + 16;

  // configuration registers
  logic [6:0]           cols_cfg_r, cols_cfg_nxt;
  logic [5:0]           rows_cfg_r, rows_cfg_nxt;
  logic                 cur_en_r, cur_en_nxt;
  logic [15:0]          dflt_color_r, dflt_color_nxt;

  // terminal state; the current row's length is col_r and its color cur_color_r,
  // its memory entry is only brought up to date when the cursor leaves the row
  logic [PW-1:0]        top_r, top_nxt;
  logic [RW-1:0]        used_r, used_nxt;
  logic [CLW-1:0]       col_r, col_nxt;
  logic                 vis_r, vis_nxt;
  logic [15:0]          cur_color_r, cur_color_nxt;
  logic [15:0]          wipe_color_r, wipe_color_nxt;
  logic [MAX_ROWS-1:0]  vld_r, vld_nxt;

  // memories
  logic [7:0]           char_mem [CS_DEPTH];
  logic [MW-1:0]        meta_mem [MAX_ROWS];
  logic [7:0]           char_q_r;
  logic [MW-1:0]        meta_q_r;
  logic                 meta_vq_r;

  // command in execution
  logic                 b_vld_r;
  opcode_t              b_op_r;
  logic [7:0]           b_ch_r;
  logic [15:0]          b_tcol_r;
  logic [4:0]           b_rrow_r;
  logic [5:0]           b_rcol_r;

  logic [CLW-1:0]       ncols, cv_col;
  logic [RW-1:0]        nrows;
  logic [PW-1:0]        cur_p, nxt_p, prv_p, in_rd_p, b_rd_p;
  logic                 acc;
  logic [OQ_AW:0]       fifo_free;
  logic                 in_bs;
  logic [PW-1:0]        meta_raddr;
  logic [AW-1:0]        char_raddr;

  logic                 char_we, meta_we;
  logic [AW-1:0]        char_waddr;
  logic [7:0]           char_wdata;
  logic [PW-1:0]        meta_waddr;
  logic [MW-1:0]        meta_wdata;

  logic [CLW-1:0]       meta_len;
  logic [15:0]          meta_color;
  logic                 b_nl, b_bs, b_wrap, hide, do_nl, wipe;
  logic [PW-1:0]        put_p;
  logic [CLW-1:0]       put_col;
  logic [RW-1:0]        put_used;
  logic                 rd_in, on_cur;
  logic [CLW-1:0]       rlen;
  logic [15:0]          rcolor;
  result_t              cur_ev, main_ev;
  logic                 has_cur, has_main, cur_shown;
  push_t                push;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] top,
                                         input logic [RW-1:0] v,
                                         input logic [RW-1:0] n);
    logic [RW:0] s;
    s = (RW + 1)'(top) + (RW + 1)'(v);
    if (s >= (RW + 1)'(n)) s = s - (RW + 1)'(n);
    return PW'(s);
  endfunction

  // register values clamped to the supported sizes
  always_comb begin
    if (cols_cfg_r == '0) begin
      ncols = CLW'(1);
    end else if (8'(cols_cfg_r) > 8'(MAX_COLS)) begin
      ncols = CLW'(MAX_COLS);
    end else begin
      ncols = CLW'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      nrows = RW'(1);
    end else if (7'(rows_cfg_r) > 7'(MAX_ROWS)) begin
      nrows = RW'(MAX_ROWS);
    end else begin
      nrows = RW'(rows_cfg_r);
    end
  end

  assign cur_p   = phys(top_r, used_r - RW'(1), nrows);
  assign nxt_p   = phys(top_r, used_r, nrows);
  assign prv_p   = phys(top_r, used_r - RW'(2), nrows);
  assign in_rd_p = phys(top_r, RW'(in_item.read_row), nrows);
  assign b_rd_p  = phys(top_r, RW'(b_rrow_r), nrows);
  // the cursor may sit just past a full row
  assign cv_col  = (col_r > ncols - CLW'(1)) ? ncols - CLW'(1) : col_r;

  // intake: no new command while one executes, room for two results required
  assign in_item.ready = rst_n && !b_vld_r && (fifo_free >= (OQ_AW + 1)'(2));
  assign acc           = in_item.valid && in_item.ready;

  assign in_bs = (in_item.char_code == CH_BS) || (in_item.char_code == CH_DEL);

  always_comb begin
    meta_raddr = nxt_p;
    char_raddr = {cur_p, CW'(cv_col)};
    unique case (opcode_t'(in_item.opcode))
      OP_PUT: begin
        meta_raddr = in_bs ? prv_p : nxt_p;
      end
      OP_READ: begin
        meta_raddr = in_rd_p;
        char_raddr = {in_rd_p, CW'(in_item.read_col)};
      end
      OP_CLEAR, OP_TICK: begin
        meta_raddr = nxt_p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      char_q_r  <= char_mem[char_raddr];
      meta_q_r  <= meta_mem[meta_raddr];
      meta_vq_r <= vld_r[meta_raddr];
      b_op_r    <= opcode_t'(in_item.opcode);
      b_ch_r    <= in_item.char_code;
      b_tcol_r  <= in_item.text_color;
      b_rrow_r  <= in_item.read_row;
      b_rcol_r  <= in_item.read_col;
    end
    if (char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
  end

  // a row not written since the last wipe reads empty in the wipe color
  assign meta_len   = meta_vq_r ? meta_q_r[MW-1:16] : '0;
  assign meta_color = meta_vq_r ? meta_q_r[15:0] : wipe_color_r;

  assign b_nl     = (b_ch_r == CH_LF) || (b_ch_r == CH_CR);
  assign b_bs     = (b_ch_r == CH_BS) || (b_ch_r == CH_DEL);
  assign b_wrap   = !b_nl && !b_bs && (col_r >= ncols);
  assign hide     = b_vld_r && (b_op_r == OP_PUT) && cur_en_r && vis_r;
  assign do_nl    = b_vld_r && (b_op_r == OP_PUT) && (b_nl || b_wrap);
  assign put_p    = b_wrap ? nxt_p : cur_p;
  assign put_col  = b_wrap ? '0 : col_r;
  assign put_used = (b_wrap && (used_r < nrows)) ? used_r + RW'(1) : used_r;

  assign rd_in  = 7'(b_rrow_r) < 7'(nrows);
  assign on_cur = (b_rd_p == cur_p);
  assign rlen   = on_cur ? col_r : meta_len;
  assign rcolor = on_cur ? cur_color_r : meta_color;

  always_comb begin
    cols_cfg_nxt   = cols_cfg_r;
    rows_cfg_nxt   = rows_cfg_r;
    cur_en_nxt     = cur_en_r;
    dflt_color_nxt = dflt_color_r;
    top_nxt        = top_r;
    used_nxt       = used_r;
    col_nxt        = col_r;
    vis_nxt        = vis_r;
    cur_color_nxt  = cur_color_r;
    wipe_color_nxt = wipe_color_r;
    vld_nxt        = vld_r;
    char_we        = 1'b0;
    char_waddr     = {put_p, CW'(put_col)};
    char_wdata     = b_ch_r;
    meta_we        = 1'b0;
    meta_waddr     = cur_p;
    meta_wdata     = {col_r, cur_color_r};
    wipe           = 1'b0;
    has_cur        = 1'b0;
    has_main       = 1'b0;
    cur_shown      = 1'b0;
    main_ev        = '0;
    main_ev.shown  = hide ? 1'b0 : vis_r;

    if (hide) begin
      has_cur = 1'b1;
      vis_nxt = 1'b0;
    end

    // leaving the current row: write back its length and color
    if (do_nl) begin
      meta_we          = 1'b1;
      vld_nxt[cur_p]   = 1'b1;
      col_nxt          = '0;
      if (used_r < nrows) begin
        used_nxt      = used_r + RW'(1);
        cur_color_nxt = meta_color;
      end else begin
        top_nxt       = (RW'(top_r) == nrows - RW'(1)) ? '0 : top_r + PW'(1);
        cur_color_nxt = dflt_color_r;
      end
    end

    if (b_vld_r) begin
      unique case (b_op_r)
        OP_PUT: begin
          if (b_nl) begin
            has_main     = 1'b1;
            main_ev.kind = EV_REDRAW;
          end else if (b_bs) begin
            if (col_r != '0) begin
              col_nxt      = col_r - CLW'(1);
              has_main     = 1'b1;
              main_ev.kind = EV_ERASE;
              main_ev.row  = 5'(used_r - RW'(1));
              main_ev.col  = 6'(col_r - CLW'(1));
            end else if (used_r > RW'(1)) begin
              // back onto the previous row, dropping its last character
              meta_we        = 1'b1;
              meta_wdata     = {{CLW{1'b0}}, cur_color_r};
              vld_nxt[cur_p] = 1'b1;
              used_nxt       = used_r - RW'(1);
              col_nxt        = (meta_len != '0) ? meta_len - CLW'(1) : '0;
              cur_color_nxt  = meta_color;
              has_main       = 1'b1;
              main_ev.kind   = EV_REDRAW;
            end
          end else begin
            if (put_col == '0) begin
              cur_color_nxt = b_tcol_r;
            end
            char_we       = 1'b1;
            col_nxt       = put_col + CLW'(1);
            has_main      = 1'b1;
            main_ev.kind  = EV_DRAW;
            main_ev.row   = 5'(put_used - RW'(1));
            main_ev.col   = 6'(put_col);
            main_ev.ch    = b_ch_r;
            main_ev.color = b_tcol_r;
          end
        end
        OP_CLEAR: begin
          wipe          = 1'b1;
          has_main      = 1'b1;
          main_ev.kind  = EV_REDRAW;
          main_ev.shown = 1'b0;
        end
        OP_TICK: begin
          if (cur_en_r) begin
            vis_nxt   = !vis_r;
            has_cur   = 1'b1;
            cur_shown = !vis_r;
          end
        end
        OP_READ: begin
          has_main      = 1'b1;
          main_ev.kind  = EV_READ;
          main_ev.row   = b_rrow_r;
          main_ev.col   = b_rcol_r;
          main_ev.shown = vis_r;
          if (rd_in) begin
            main_ev.ch    = (8'(b_rcol_r) < 8'(rlen)) ? char_q_r : 8'd0;
            main_ev.color = rcolor;
          end else begin
            main_ev.color = dflt_color_r;
          end
        end
      endcase
    end

    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COLUMNS: begin
          cols_cfg_nxt = cfg_wdata[6:0];
          wipe         = 1'b1;
        end
        CFG_ROWS: begin
          rows_cfg_nxt = cfg_wdata[5:0];
          wipe         = 1'b1;
        end
        CFG_CURSOR_EN: begin
          cur_en_nxt = cfg_wdata[0];
          vis_nxt    = 1'b0;
        end
        CFG_COLOR: begin
          dflt_color_nxt = cfg_wdata;
        end
      endcase
    end

    if (wipe) begin
      vld_nxt        = '0;
      wipe_color_nxt = dflt_color_r;
      cur_color_nxt  = dflt_color_r;
      top_nxt        = '0;
      used_nxt       = RW'(1);
      col_nxt        = '0;
      vis_nxt        = 1'b0;
    end
  end

  // cursor event shows the cell under the cursor in the current row's color
  always_comb begin
    cur_ev       = '0;
    cur_ev.kind  = EV_CURSOR;
    cur_ev.row   = 5'(used_r - RW'(1));
    cur_ev.col   = 6'(cv_col);
    cur_ev.ch    = (cv_col < col_r) ? char_q_r : 8'd0;
    cur_ev.color = cur_color_r;
    cur_ev.shown = cur_shown;
    cur_ev.last  = !has_main;
    push         = '0;
    if (has_cur) begin
      push.ev[0]      = cur_ev;
      push.ev[1]      = main_ev;
      push.ev[1].last = 1'b1;
      push.count      = has_main ? 2'd2 : 2'd1;
    end else if (has_main) begin
      push.ev[0]      = main_ev;
      push.ev[0].last = 1'b1;
      push.count      = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r      <= 1'b0;
      cols_cfg_r   <= RST_COLUMNS;
      rows_cfg_r   <= RST_ROWS;
      cur_en_r     <= 1'b0;
      dflt_color_r <= RST_COLOR;
      top_r        <= '0;
      used_r       <= RW'(1);
      col_r        <= '0;
      vis_r        <= 1'b0;
      cur_color_r  <= RST_COLOR;
      wipe_color_r <= RST_COLOR;
      vld_r        <= '0;
    end else begin
      b_vld_r      <= acc;
      cols_cfg_r   <= cols_cfg_nxt;
      rows_cfg_r   <= rows_cfg_nxt;
      cur_en_r     <= cur_en_nxt;
      dflt_color_r <= dflt_color_nxt;
      top_r        <= top_nxt;
      used_r       <= used_nxt;
      col_r        <= col_nxt;
      vis_r        <= vis_nxt;
      cur_color_r  <= cur_color_nxt;
      wipe_color_r <= wipe_color_nxt;
      vld_r        <= vld_nxt;
    end
  end

  ttlb_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .free     (fifo_free),
    .out_item (out_item)
  );

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= ncols)
    else $error("cursor column beyond row width");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= nrows))
    else $error("rows in use out of range");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    RW'(top_r) < nrows)
    else $error("top row pointer out of range");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> (fifo_free >= (OQ_AW + 1)'(2)))
    else $error("result queue lacks room for an executing item");

endmodule
